@@ src/pat_pkg.sv @@
package pat_pkg;

    localparam logic [31:0] TRACE_INIT = 32'd21474836;
    localparam logic [15:0] RATE_RESET = 16'd205;

    localparam logic [1:0] OP_PRE    = 2'd0;
    localparam logic [1:0] OP_POST   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_RATE   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRE_UPD,
        ST_POST_RD,
        ST_POST_WR,
        ST_WALK,
        ST_RD_ISSUE,
        ST_RD_OUT
    } state_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        pre_wr;
        logic        rd;
        logic        clr;
        logic [15:0] sample;
        logic [15:0] rate;
    } cell_cmd_t;

    // Move trace toward target by rate/65536, step rounded toward minus infinity.
    function automatic logic [31:0] smooth(input logic [31:0] trace,
                                           input logic [31:0] target,
                                           input logic [15:0] rate);
        logic signed [32:0] diff;
        logic signed [49:0] prod;
        logic signed [33:0] delta;
        diff  = $signed({1'b0, target}) - $signed({1'b0, trace});
        prod  = diff * $signed({1'b0, rate});
        delta = prod[49:16];
        return trace + delta[31:0];
    endfunction

endpackage

@@ src/pat_cell.sv @@
module pat_cell #(
    parameter int POST_UNITS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pat_pkg::cell_cmd_t                     cmd,
    input  logic                                   sel,
    input  logic [(POST_UNITS > 1 ? $clog2(POST_UNITS) : 1)-1:0] addr,
    input  logic                                   tok_in,
    output logic                                   tok_out,
    output logic [31:0]                            pre_trace,
    output logic [31:0]                            joint_rd
);
    import pat_pkg::*;

    logic [15:0] pre_sample_reg;
    logic [31:0] pre_trace_reg;
    logic [31:0] target_reg;
    logic [31:0] rd_data_reg;
    logic        tok_reg;
    logic [31:0] col_mem [POST_UNITS];

    logic [31:0] prod;
    logic [32:0] tgt_wide;
    logic [31:0] sm_trace;
    logic [31:0] sm_target;
    logic [31:0] sm_result;

    assign prod     = 32'(pre_sample_reg) * 32'(cmd.sample);
    assign tgt_wide = {prod, 1'b0};

    // one smoothing unit, shared by the joint step and the pre update
    always_comb
    begin
        if (tok_reg)
        begin
            sm_trace  = rd_data_reg;
            sm_target = target_reg;
        end
        else
        begin
            sm_trace  = pre_trace_reg;
            sm_target = {cmd.sample, 16'd0};
        end
        sm_result = smooth(sm_trace, sm_target, cmd.rate);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= 1'b0;
            pre_trace_reg <= TRACE_INIT;
        end
        else
        begin
            tok_reg <= tok_in;
            if (cmd.pre_wr && sel)
            begin
                pre_trace_reg <= sm_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pre_wr && sel)
        begin
            pre_sample_reg <= cmd.sample;
        end
        if (tok_in)
        begin
            target_reg <= tgt_wide[32] ? 32'hFFFF_FFFF : tgt_wide[31:0];
        end
        if (tok_in || cmd.rd)
        begin
            rd_data_reg <= col_mem[addr];
        end
        if (cmd.clr)
        begin
            col_mem[addr] <= TRACE_INIT;
        end
        else if (tok_reg)
        begin
            col_mem[addr] <= sm_result;
        end
    end

    assign tok_out   = tok_reg;
    assign pre_trace = pre_trace_reg;
    assign joint_rd  = rd_data_reg;

endmodule

@@ src/pairwise_activity_trace_update.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | opcode, pre_index, post_index, sample
// out     | output    | out_valid/out_stall | pre_trace_out, post_trace_out, joint_trace_out
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Steps: a pre passes PRE_UPD, a read RD_ISSUE and RD_OUT, a post POST_RD, POST_WR
//   and WALK, where a token passes down the cell row, one cell per cycle.
// Reset: a clearing pass over all POST_UNITS entries rewrites the joint and post trace
//   memories; in_stall stays high during it.
// Stalls: a read result waits in the output register while out_stall is high;
//   a further read waits until that register is free.
module pairwise_activity_trace_update #(
    parameter int PRE_UNITS  = 64,
    parameter int POST_UNITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [5:0]  pre_index,
    input  logic [5:0]  post_index,
    input  logic [15:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pre_trace_out,
    output logic [31:0] post_trace_out,
    output logic [31:0] joint_trace_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import pat_pkg::*;

    localparam int PRE_IW  = PRE_UNITS > 1 ? $clog2(PRE_UNITS) : 1;
    localparam int QI      = POST_UNITS > 1 ? $clog2(POST_UNITS) : 1;
    localparam int MAXU    = PRE_UNITS > POST_UNITS ? PRE_UNITS : POST_UNITS;
    localparam int CW      = $clog2(MAXU + 1);

    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        enable_reg;
    logic [15:0] rate_reg;

    // transaction fields held while it is worked on
    logic [1:0]  op_reg;
    logic [5:0]  pi_reg;
    logic [5:0]  q_reg;
    logic [15:0] s_reg;

    logic        out_valid_reg;
    logic [31:0] pre_out_reg, post_out_reg, joint_out_reg;

    logic [31:0] post_mem [POST_UNITS];
    logic [31:0] post_rd_reg;

    cell_cmd_t   cmd;
    logic [QI-1:0] col_addr;
    logic [PRE_IW-1:0] pre_sel;
    logic        tok_launch;
    logic        tok [PRE_UNITS+1];
    logic [31:0] cell_pre [PRE_UNITS];
    logic [31:0] cell_joint [PRE_UNITS];

    logic        accept;
    logic        pre_ok, post_ok, in_pre_ok, in_post_ok;
    logic        out_load;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_pre_ok  = 32'(pre_index) < PRE_UNITS;
    assign in_post_ok = 32'(post_index) < POST_UNITS;
    assign pre_ok     = 32'(pi_reg) < PRE_UNITS;
    assign post_ok    = 32'(q_reg) < POST_UNITS;
    assign pre_sel    = PRE_IW'(pi_reg);
    assign col_addr   = (state_reg == ST_CLEAR) ? cnt_reg[QI-1:0] : QI'(q_reg);
    assign out_load   = (state_reg == ST_RD_OUT) && (!out_valid_reg || !out_stall);
    assign tok[0]     = tok_launch;

    // sequencer: next state, counter and cell command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.pre_wr = 1'b0;
        cmd.rd     = 1'b0;
        cmd.clr    = 1'b0;
        cmd.sample = s_reg;
        cmd.rate   = rate_reg;
        tok_launch = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(POST_UNITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_PRE:  state_next = (enable_reg && in_pre_ok) ? ST_PRE_UPD : ST_IDLE;
                        OP_POST: state_next = (enable_reg && in_post_ok) ? ST_POST_RD : ST_IDLE;
                        OP_READ: state_next = ST_RD_ISSUE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PRE_UPD:
            begin
                cmd.pre_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_POST_RD:
            begin
                state_next = ST_POST_WR;
            end
            ST_POST_WR:
            begin
                // launch the token into the first cell
                tok_launch = 1'b1;
                cnt_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // the last cell writes back at the end of the final walk cycle
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PRE_UNITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            enable_reg    <= 1'b1;
            rate_reg      <= RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE: enable_reg <= cfg_data[0];
                    CFG_RATE:   rate_reg   <= cfg_data;
                    default:    rate_reg   <= rate_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the transaction fields; post trace memory and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= opcode;
            pi_reg <= pre_index;
            q_reg  <= post_index;
            s_reg  <= sample;
        end
        if (state_reg == ST_POST_RD || state_reg == ST_RD_ISSUE)
        begin
            post_rd_reg <= post_mem[col_addr];
        end
        if (state_reg == ST_CLEAR)
        begin
            post_mem[col_addr] <= TRACE_INIT;
        end
        else if (state_reg == ST_POST_WR)
        begin
            post_mem[col_addr] <= smooth(post_rd_reg, {s_reg, 16'd0}, rate_reg);
        end
        if (out_load)
        begin
            pre_out_reg   <= pre_ok ? cell_pre[pre_sel] : 32'd0;
            post_out_reg  <= post_ok ? post_rd_reg : 32'd0;
            joint_out_reg <= (pre_ok && post_ok) ? cell_joint[pre_sel] : 32'd0;
        end
    end

    // one cell per pre unit: its sample, its trace and its joint column
    for (genvar i = 0; i < PRE_UNITS; i++)
    begin : g_cell
        pat_cell #(
            .POST_UNITS(POST_UNITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (pre_sel == PRE_IW'(i)),
            .addr      (col_addr),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1]),
            .pre_trace (cell_pre[i]),
            .joint_rd  (cell_joint[i])
        );
    end

    assign out_valid       = out_valid_reg;
    assign pre_trace_out   = pre_out_reg;
    assign post_trace_out  = post_out_reg;
    assign joint_trace_out = joint_out_reg;

`ifndef SYNTHESIS
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && cnt_reg == CW'(PRE_UNITS - 1)) |=> (state_reg == ST_IDLE))
        else $error("post walk did not end after the last cell");
    a_tok_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        tok_launch |-> (enable_reg && post_ok && op_reg == OP_POST))
        else $error("token launched for a transaction that must not update");
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RD_OUT && op_reg == OP_READ))
        else $error("result produced outside a read");
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("transaction accepted during the clearing pass");
`endif

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import pat_pkg::*;

    localparam int NPRE  = 64;
    localparam int NPOST = 64;
    // Cycles without any accepted transaction or result before the run is abandoned:
    // clearing pass, a post walk, and the longest random stall, several times over.
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [5:0]  pre_index;
    logic [5:0]  post_index;
    logic [15:0] sample;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pre_trace_out;
    logic [31:0] post_trace_out;
    logic [31:0] joint_trace_out;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    pairwise_activity_trace_update #(.PRE_UNITS(NPRE), .POST_UNITS(NPOST)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .pre_index(pre_index), .post_index(post_index), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .pre_trace_out(pre_trace_out), .post_trace_out(post_trace_out),
        .joint_trace_out(joint_trace_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [31:0] pre_tr;
        logic [31:0] post_tr;
        logic [31:0] joint_tr;
    } trace_triple_t;

    // Shadow copy of the block state.
    logic        en_q;
    logic [15:0] rate_q;
    logic [15:0] pre_samples [NPRE];
    logic        pre_written [NPRE];
    logic [31:0] pre_traces  [NPRE];
    logic [31:0] post_traces [NPOST];
    logic [31:0] joint_traces[NPRE*NPOST];

    trace_triple_t pending_reads[$];

    int errors;
    int idle_pct;   // sender idle percentage
    int stall_pct;  // receiver stall percentage
    int quiet_cycles;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Step a trace toward its target, rounding the step toward minus infinity.
    function automatic logic [31:0] approach(input logic [31:0] cur, input logic [31:0] goal,
                                             input logic [15:0] r);
        longint d;
        longint p;
        longint step;
        d = longint'({32'd0, goal}) - longint'({32'd0, cur});
        p = d * longint'({48'd0, r});
        step = p >>> 16;
        return cur + step[31:0];
    endfunction

    // Advance the shadow state by one transaction; return 1 when a read result is due.
    function automatic bit predict_traces(input logic [1:0] op, input logic [5:0] pi,
                                          input logic [5:0] qi, input logic [15:0] s,
                                          output trace_triple_t res);
        logic [32:0] prod;
        logic [31:0] goal;
        res = '0;
        if (op == OP_PRE)
        begin
            if (en_q)
            begin
                pre_samples[pi] = s;
                pre_written[pi] = 1'b1;
                pre_traces[pi] = approach(pre_traces[pi], {s, 16'd0}, rate_q);
            end
            return 1'b0;
        end
        if (op == OP_POST)
        begin
            if (en_q)
            begin
                post_traces[qi] = approach(post_traces[qi], {s, 16'd0}, rate_q);
                for (int i = 0; i < NPRE; i++)
                begin
                    prod = {32'(pre_samples[i]) * 32'(s), 1'b0};
                    goal = prod[32] ? 32'hFFFF_FFFF : prod[31:0];
                    joint_traces[i*NPOST+qi] = approach(joint_traces[i*NPOST+qi], goal, rate_q);
                end
            end
            return 1'b0;
        end
        if (op == OP_READ)
        begin
            res.pre_tr   = pre_traces[pi];
            res.post_tr  = post_traces[qi];
            res.joint_tr = joint_traces[pi*NPOST+qi];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Drive one transaction, then wait for a clock edge and until in_stall is low; valid drops on the next idle.
    task automatic send_item(input logic [1:0] op, input logic [5:0] pi,
                             input logic [5:0] qi, input logic [15:0] s);
        trace_triple_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        pre_index  <= pi;
        post_index <= qi;
        sample     <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_traces(op, pi, qi, s, res))
            pending_reads.insert(pending_reads.size(), res);
    endtask

    // Wait for all reads to return, plus the longest post walk.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reads.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (NPRE + 10) @(posedge clk);
    endtask

    // Stop sending and wait until every read has come back.
    task automatic wait_reads();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ENABLE)
            en_q = val[0];
        else
            rate_q = val;
    endtask

    // Corner values mixed with random ones.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_seed_samples();
        // Write every pre sample once so post walks read defined values.
        for (int i = 0; i < NPRE; i++)
            send_item(OP_PRE, 6'(i), 6'($urandom), rand_sample());
    endtask

    task automatic test_directed();
        send_item(OP_READ, 6'd0, 6'd0, 16'd0);
        send_item(OP_READ, 6'd63, 6'd63, 16'hFFFF);
        send_item(OP_PRE, 6'd0, 6'd0, 16'hFFFF);
        send_item(OP_PRE, 6'd63, 6'd0, 16'd0);
        send_item(OP_POST, 6'd0, 6'd0, 16'hFFFF);   // joint target saturates
        send_item(OP_POST, 6'd0, 6'd63, 16'd32768);
        send_item(OP_POST, 6'd0, 6'd5, 16'd0);
        send_item(OP_UNUSED, 6'd7, 6'd9, 16'h1234); // unused opcode: no result
        send_item(OP_READ, 6'd0, 6'd0, 16'd0);
        send_item(OP_READ, 6'd63, 6'd63, 16'd0);
        send_item(OP_READ, 6'd0, 6'd5, 16'd0);
    endtask

    task automatic test_disabled();
        write_reg(CFG_ENABLE, 16'd0);
        send_item(OP_PRE, 6'd3, 6'd0, 16'd40000);
        send_item(OP_POST, 6'd0, 6'd3, 16'd40000);
        send_item(OP_READ, 6'd3, 6'd3, 16'd0);
        write_reg(CFG_ENABLE, 16'd1);
        send_item(OP_READ, 6'd3, 6'd3, 16'd0);
    endtask

    task automatic test_random(input int count);
        logic [1:0] op;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_PRE;
                4:          op = OP_POST;
                5:          op = OP_UNUSED;
                default:    op = OP_READ;
            endcase
            send_item(op, 6'($urandom), 6'($urandom), rand_sample());
        end
    endtask

    task automatic test_rates();
        logic [15:0] rates[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd205};
        foreach (rates[k])
        begin
            write_reg(CFG_RATE, rates[k]);
            test_random(60);
        end
    endtask

    task automatic test_idle_phases();
        int idles[4] = '{0, 60, 0, 10};
        int stalls[4] = '{0, 0, 60, 10};
        foreach (idles[k])
        begin
            idle_pct  = idles[k];
            stall_pct = stalls[k];
            write_reg(CFG_RATE, 16'($urandom));
            test_random(220);
            // Hold off until every read has come back, then go on.
            wait_reads();
        end
    endtask

    // Check each accepted result against the oldest expected read.
    always @(posedge clk)
    begin
        trace_triple_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                report_mismatch("unexpected result count", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_reads.pop_front();
                if (pre_trace_out !== want.pre_tr)
                    report_mismatch("pre_trace_out", pre_trace_out, want.pre_tr);
                if (post_trace_out !== want.post_tr)
                    report_mismatch("post_trace_out", post_trace_out, want.post_tr);
                if (joint_trace_out !== want.joint_tr)
                    report_mismatch("joint_trace_out", joint_trace_out, want.joint_tr);
            end
        end
    end

    // Drive the receiver stall at random.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_READ;
        pre_index = '0;
        post_index = '0;
        sample = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        en_q = 1'b1;
        rate_q = RATE_RESET;
        for (int i = 0; i < NPRE; i++)
        begin
            pre_samples[i] = '0;
            pre_written[i] = 1'b0;
            pre_traces[i] = TRACE_INIT;
        end
        for (int i = 0; i < NPOST; i++)
            post_traces[i] = TRACE_INIT;
        for (int i = 0; i < NPRE*NPOST; i++)
            joint_traces[i] = TRACE_INIT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_seed_samples();
        test_directed();
        test_disabled();
        test_rates();
        test_idle_phases();
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
